// ----- hw/rtl/sbmmn_pkg.sv -----
// Package for the stereo block min-max normalizer: sizes, codes, sample
// type, controller state encoding. No dependencies.
`default_nettype none

package sbmmn_pkg;

   // Block geometry and sample format
   localparam int BLOCK_DEPTH = 256;
   localparam int SAMPLE_BITS = 24;

   // Configuration register (block_length)
   localparam int CFG_BITS  = 9;
   localparam int CFG_RESET = 256;

   localparam int CNT_BITS  = $clog2(BLOCK_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(BLOCK_DEPTH);
   localparam int LEN_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

   // Stream payload: two samples packed, padded to whole bytes
   localparam int DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   // Divider: quotient bits retired per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_GROUPS = (SAMPLE_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int QUO_BITS   = DIV_GROUPS * DIV_STEP;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // Request op codes (req_tuser)
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Response status codes (rsp_tuser)
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sbmmn_div.sv -----
// Per-channel normalizing divider: maps a sample into [-1, +1) given the
// channel's min and max. Radix-2^DIV_STEP restoring division. Uses sbmmn_pkg.
`default_nettype none

module sbmmn_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sbmmn_pkg::sample_type sample,
   input  sbmmn_pkg::sample_type lo,
   input  sbmmn_pkg::sample_type hi,
   output logic                  done,
   output sbmmn_pkg::sample_type result
);
   import sbmmn_pkg::*;

   localparam int REM_BITS = SAMPLE_BITS + 1;
   localparam int GRP_BITS = $clog2(DIV_GROUPS + 1);

   logic [GRP_BITS-1:0]    cnt_ff, cnt_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] dvs_ff, dvs_in;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;
   logic                   flat_ff, flat_in;
   logic                   sat_ff, sat_in;
   logic                   done_ff, done_in;

   logic signed [SAMPLE_BITS:0] diff_x;
   logic signed [SAMPLE_BITS:0] diff_r;
   logic [SAMPLE_BITS-1:0]      quo_top;

   assign diff_x = {sample[SAMPLE_BITS-1], sample} - {lo[SAMPLE_BITS-1], lo};
   assign diff_r = {hi[SAMPLE_BITS-1], hi} - {lo[SAMPLE_BITS-1], lo};

   always_comb begin
      logic [REM_BITS-1:0] rem_t;
      logic [QUO_BITS-1:0] quo_t;
      rem_t   = rem_ff;
      quo_t   = quo_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      flat_in = flat_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         // below-min sample clamps to a zero offset
         rem_in  = diff_x[SAMPLE_BITS] ? '0 : {1'b0, diff_x[SAMPLE_BITS-1:0]};
         dvs_in  = diff_r[SAMPLE_BITS-1:0];
         flat_in = (hi <= lo);
         quo_in  = '0;
         cnt_in  = GRP_BITS'(DIV_GROUPS);
      end else if (cnt_ff != '0) begin
         // offset >= range means the quotient reaches +1: saturate
         if (cnt_ff == GRP_BITS'(DIV_GROUPS)) begin
            sat_in = (rem_ff >= {1'b0, dvs_ff});
         end
         for (int j = 0; j < DIV_STEP; j++) begin
            rem_t = {rem_t[REM_BITS-2:0], 1'b0};
            if (rem_t >= {1'b0, dvs_ff}) begin
               rem_t = rem_t - {1'b0, dvs_ff};
               quo_t = {quo_t[QUO_BITS-2:0], 1'b1};
            end else begin
               quo_t = {quo_t[QUO_BITS-2:0], 1'b0};
            end
         end
         rem_in  = rem_t;
         quo_in  = quo_t;
         cnt_in  = cnt_ff - GRP_BITS'(1);
         done_in = (cnt_ff == GRP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      flat_ff <= flat_in;
      sat_ff  <= sat_in;
   end

   // extra low quotient bits from rounding up the group count drop out here
   assign quo_top = quo_ff[QUO_BITS-1 -: SAMPLE_BITS];

   always_comb begin
      if (flat_ff) begin
         result = '0;
      end else if (sat_ff) begin
         result = SAMPLE_MAX;
      end else begin
         result = {~quo_top[SAMPLE_BITS-1], quo_top[SAMPLE_BITS-2:0]};
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_block_minmax_normalizer.sv -----
// Stereo block min-max normalizer top level: channel stores, min/max
// tracking, request controller, output register. Uses sbmmn_pkg, sbmmn_div.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: left, right; tuser: op
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: left, right; tlast: block
//          |     |                       |   end; tuser: status
//  csr     | in  | csr_valid/csr_ready   | csr_data: block_length
//
// A load request does the store write and the min/max update together.
// A read request on a full block does a store read, then both dividers
// retiring DIV_STEP quotient bits per cycle, then the output register
// load. A read on a block that is not full returns a status.
// While rsp is stalled a finished result waits in the push state; one more
// result may sit in the output register. Synchronous active-high reset; the
// stores are not cleared, only written entries are ever read.
`default_nettype none

module stereo_block_minmax_normalizer (
   input  logic                                clock,
   input  logic                                reset,
   // request: [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS]
   // right_sample, rest zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sbmmn_pkg::DATA_BITS-1:0]     req_tdata,
   input  logic                                req_tuser,   // [0] op
   // response: [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS]
   // right_out, rest zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sbmmn_pkg::DATA_BITS-1:0]     rsp_tdata,
   output logic                                rsp_tlast,   // block_end
   output logic                                rsp_tuser,   // [0] status
   // configuration: block_length
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbmmn_pkg::CFG_BITS-1:0]      csr_data
);
   import sbmmn_pkg::*;

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [CFG_BITS-1:0]    block_length_ff;
   logic [CNT_BITS-1:0]    fill_count_ff, fill_count_in;
   logic [CNT_BITS-1:0]    read_index_ff, read_index_in;
   sample_type             left_min_ff, left_min_in;
   sample_type             left_max_ff, left_max_in;
   sample_type             right_min_ff, right_min_in;
   sample_type             right_max_ff, right_max_in;
   logic                   notready_ff, notready_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_BITS-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;
   logic                   rsp_tuser_ff, rsp_tuser_in;

   // channel stores, one synchronous read port each
   sample_type             left_store_ff [BLOCK_DEPTH];
   sample_type             right_store_ff [BLOCK_DEPTH];
   sample_type             left_rd_ff;
   sample_type             right_rd_ff;

   // ---------------------------------------------------------------------
   // Decode
   // ---------------------------------------------------------------------
   logic [LEN_BITS-1:0]    cfg_ext;
   logic [CNT_BITS-1:0]    eff_len;
   logic [CNT_BITS-1:0]    read_next;
   logic                   block_full;
   logic                   last_read;
   logic                   req_accept;
   logic                   is_read;
   logic                   wr_en;
   logic                   rd_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [ADDR_BITS-1:0]   rd_addr;
   sample_type             req_left;
   sample_type             req_right;
   logic                   div_start;
   logic                   push;
   logic                   left_done;
   logic                   right_done;
   sample_type             left_norm;
   sample_type             right_norm;

   // zero length acts as one, anything past the store depth as the depth
   assign cfg_ext = LEN_BITS'(block_length_ff);
   always_comb begin
      if (cfg_ext == '0) begin
         eff_len = CNT_BITS'(1);
      end else if (cfg_ext > LEN_BITS'(BLOCK_DEPTH)) begin
         eff_len = CNT_BITS'(BLOCK_DEPTH);
      end else begin
         eff_len = CNT_BITS'(cfg_ext);
      end
   end

   assign read_next  = read_index_ff + CNT_BITS'(1);
   assign block_full = (fill_count_ff >= eff_len);
   assign last_read  = (read_next >= eff_len);

   assign req_accept = req_tvalid & req_tready;
   assign is_read    = (req_tuser == OP_READ);
   assign req_left   = req_tdata[SAMPLE_BITS-1:0];
   assign req_right  = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   // a load on a full block is dropped
   assign wr_en   = req_accept & ~is_read & ~block_full;
   assign rd_en   = req_accept & is_read & block_full;
   assign wr_addr = fill_count_ff[ADDR_BITS-1:0];
   assign rd_addr = read_index_ff[ADDR_BITS-1:0];

   // ---------------------------------------------------------------------
   // Stores
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_store_ff[wr_addr]  <= req_left;
         right_store_ff[wr_addr] <= req_right;
      end
      if (rd_en) begin
         left_rd_ff  <= left_store_ff[rd_addr];
         right_rd_ff <= right_store_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Dividers, one per channel
   // ---------------------------------------------------------------------
   sbmmn_div u_left_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sample (left_rd_ff),
      .lo     (left_min_ff),
      .hi     (left_max_ff),
      .done   (left_done),
      .result (left_norm)
   );

   sbmmn_div u_right_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sample (right_rd_ff),
      .lo     (right_min_ff),
      .hi     (right_max_ff),
      .done   (right_done),
      .result (right_norm)
   );

   // ---------------------------------------------------------------------
   // Controller: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_read) begin
               state_in = block_full ? ST_FETCH : ST_PUSH;
            end
         end
         ST_FETCH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (left_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Controller: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      push       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_FETCH: begin
            // store read data is registered by now
            div_start = 1'b1;
         end
         ST_DIVIDE: begin
         end
         ST_PUSH: begin
            push = ~rsp_tvalid_ff | rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Block bookkeeping and output register
   // ---------------------------------------------------------------------
   always_comb begin
      fill_count_in = fill_count_ff;
      read_index_in = read_index_ff;
      left_min_in   = left_min_ff;
      left_max_in   = left_max_ff;
      right_min_in  = right_min_ff;
      right_max_in  = right_max_ff;
      notready_in   = notready_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;

      if (req_accept && is_read) begin
         notready_in = ~block_full;
      end

      if (wr_en) begin
         fill_count_in = fill_count_ff + CNT_BITS'(1);
         if (req_left < left_min_ff)   left_min_in  = req_left;
         if (req_left > left_max_ff)   left_max_in  = req_left;
         if (req_right < right_min_ff) right_min_in = req_right;
         if (req_right > right_max_ff) right_max_in = req_right;
      end

      if (push) begin
         rsp_tvalid_in = 1'b1;
         if (notready_ff) begin
            rsp_tdata_in = '0;
            rsp_tlast_in = 1'b0;
            rsp_tuser_in = STATUS_NOT_READY;
         end else begin
            rsp_tdata_in = DATA_BITS'({right_norm, left_norm});
            rsp_tlast_in = last_read;
            rsp_tuser_in = STATUS_OK;
            if (last_read) begin
               // block drained: empty it for the next fill
               fill_count_in = '0;
               read_index_in = '0;
               left_min_in   = SAMPLE_MAX;
               left_max_in   = SAMPLE_MIN;
               right_min_in  = SAMPLE_MAX;
               right_max_in  = SAMPLE_MIN;
            end else begin
               read_index_in = read_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         block_length_ff <= CFG_BITS'(CFG_RESET);
         fill_count_ff   <= '0;
         read_index_ff   <= '0;
         left_min_ff     <= SAMPLE_MAX;
         left_max_ff     <= SAMPLE_MIN;
         right_min_ff    <= SAMPLE_MAX;
         right_max_ff    <= SAMPLE_MIN;
         notready_ff     <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_valid && csr_ready) begin
            block_length_ff <= csr_data;
         end
         fill_count_ff <= fill_count_in;
         read_index_ff <= read_index_in;
         left_min_ff   <= left_min_in;
         left_max_ff   <= left_max_in;
         right_min_ff  <= right_min_in;
         right_max_ff  <= right_max_in;
         notready_ff   <= notready_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_BITS'(BLOCK_DEPTH))
      else $error("fill count past store depth");

   a_read_behind_fill: assert property (@(posedge clock) disable iff (reset)
      (read_index_ff == '0) || (read_index_ff < fill_count_ff))
      else $error("read index ahead of fill count");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fill_count_ff == $past(fill_count_ff) + CNT_BITS'(1)))
      else $error("accepted load not counted");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && left_done) |-> right_done)
      else $error("channel dividers out of step");

   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      (fill_count_ff != '0) |->
         (left_min_ff <= left_max_ff) && (right_min_ff <= right_max_ff))
      else $error("channel min above max on a non-empty block");

endmodule

`default_nettype wire
